FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the rational arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and codes of the rational arithmetic unit.
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam int KIND_W     = 3;
    localparam int FIELD_W    = 32;
    localparam int RES_DEN_W  = 31;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = FIELD_W + RES_DEN_W + 1;

    localparam logic [KIND_W-1:0] KIND_MAKE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RECIP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EQUAL = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/rau_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Registered unsigned multiplier shared by all cross products.
module rau_mul
    import rau_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic [WIDTH-1:0]     x,
    input  wire logic [WIDTH-1:0]     y,
    output logic      [2*WIDTH-1:0]   p
);

    logic [2*WIDTH-1:0] p_reg;
    logic [2*WIDTH-1:0] p_next;

    assign p_next = x * y;

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/rau_red.sv
`timescale 1ns / 1ps
`default_nettype none
// Reduction unit: binary GCD then two restoring divisions on one subtractor.
module rau_red
    import rau_pkg::*;
#(
    parameter int VAL_W = 2 * WORD_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [VAL_W-1:0]  n_in,
    input  wire logic [VAL_W-1:0]  d_in,
    output logic                   done,
    output logic      [VAL_W-1:0]  q_num,
    output logic      [VAL_W-1:0]  q_den
);

    localparam int CNT_W = $clog2(VAL_W);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_GCD  = 3'd1;
    localparam logic [2:0] PH_SHL  = 3'd2;
    localparam logic [2:0] PH_DIVN = 3'd3;
    localparam logic [2:0] PH_DIVD = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] u_reg, u_next;
    logic [VAL_W-1:0] v_reg, v_next;
    logic [VAL_W-1:0] n_reg, n_next;
    logic [VAL_W-1:0] d_reg, d_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0] qn_reg, qn_next;

    logic             u_gt_v;
    logic [VAL_W:0]   sub_a, sub_b;
    logic [VAL_W+1:0] diff;
    logic             borrow;
    logic [VAL_W-1:0] step_quo, step_rem;

    // The one subtractor: big minus small during GCD, trial subtract in division.
    assign u_gt_v = u_reg > v_reg;

    always_comb begin
        if (phase_reg == PH_GCD) begin
            sub_a = u_gt_v ? {1'b0, u_reg} : {1'b0, v_reg};
            sub_b = u_gt_v ? {1'b0, v_reg} : {1'b0, u_reg};
        end else begin
            sub_a = {rem_reg, quo_reg[VAL_W-1]};
            sub_b = {1'b0, u_reg};
        end
    end

    assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow   = diff[VAL_W+1];
    assign step_quo = {quo_reg[VAL_W-2:0], ~borrow};
    assign step_rem = borrow ? sub_a[VAL_W-1:0] : diff[VAL_W-1:0];

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        qn_next    = qn_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    n_next   = n_in;
                    d_next   = d_in;
                    u_next   = n_in;
                    v_next   = d_in;
                    cnt_next = '0;
                    if (n_in == '0) begin
                        // Zero numerator reduces to 0/1 at once.
                        qn_next   = '0;
                        quo_next  = VAL_W'(1);
                        done_next = 1'b1;
                    end else begin
                        phase_next = PH_GCD;
                    end
                end
            end
            PH_GCD: begin
                if (u_reg == v_reg) begin
                    phase_next = PH_SHL;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next   = u_reg >> 1;
                    v_next   = v_reg >> 1;
                    cnt_next = cnt_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_gt_v) begin
                    u_next = diff[VAL_W:1];
                end else begin
                    v_next = diff[VAL_W:1];
                end
            end
            PH_SHL: begin
                // Put back the common factors of two, one per cycle.
                if (cnt_reg == '0) begin
                    phase_next = PH_DIVN;
                    quo_next   = n_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(VAL_W - 1);
                end else begin
                    u_next   = u_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            PH_DIVN: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    qn_next    = step_quo;
                    quo_next   = d_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(VAL_W - 1);
                    phase_next = PH_DIVD;
                end
            end
            PH_DIVD: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        qn_reg  <= qn_next;
    end

    assign done  = done_reg;
    assign q_num = qn_reg;
    assign q_den = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the rational arithmetic unit: sequencer, operand handling, output register.
//
//  Channel | Direction | Ports                                     | Word carries
//  --------+-----------+-------------------------------------------+-----------------------
//  s_      | in        | s_tvalid, s_tready, s_tdata[127:0], s_tuser | two fractions, kind
//  m_      | out       | m_tvalid, m_tready, m_tdata[63:0], m_tuser  | reduced fraction,
//          |           |                                           | equal flag, status
//
// A rejected word (unused kind, zero denominator, division by zero) goes from S_IDLE straight
// to S_FIN, which writes the output register; an equality test first runs S_MUL0 to S_SUM.
// Make, add, multiply, divide and reciprocal also pass through the reduction unit, whose run
// time is set by the bit-serial GCD and the two restoring divisions that share its
// subtractor. A zero numerator skips the GCD and the divisions in the reduction unit.
// aresetn, sampled on the rising edge of aclk, clears the sequencer and the output valid.
// The next word is accepted while a result waits in the output register; only a second
// finished result waits for the first to be taken.
`include "assert_macros.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // kind [2:0]
    input  wire logic [KIND_W-1:0]      s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // res_num [31:0], res_den [62:32], equal [63]
    output logic      [OUT_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic      [STATUS_W-1:0]    m_tuser
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;

    localparam logic [PW-1:0] HALF  = PW'(1) << (W - 1);
    localparam logic [W-1:0]  ONE_W = W'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_GO   = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    // Magnitude of the sign extension of a field's low W bits.
    function automatic logic [W-1:0] mag_of(input logic [FIELD_W-1:0] f);
        logic [W-1:0] low;
        low = f[W-1:0];
        return low[W-1] ? (~low + ONE_W) : low;
    endfunction

    logic [2:0]           state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [W-1:0]         an_reg, an_next, ad_reg, ad_next;
    logic [W-1:0]         bn_reg, bn_next, bd_reg, bd_next;
    logic                 an_neg_reg, an_neg_next, ad_neg_reg, ad_neg_next;
    logic                 bn_neg_reg, bn_neg_next, bd_neg_reg, bd_neg_next;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic                 eq_reg, eq_next;
    logic                 sign_reg, sign_next;
    logic [PW-1:0]        l_reg, l_next, r_reg, r_next;
    logic [PW-1:0]        n_reg, n_next, d_reg, d_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    logic [W-1:0]         in_an, in_ad, in_bn, in_bd;
    logic                 uses_b;

    logic [W-1:0]         mul_x, mul_y;
    logic [PW-1:0]        prod;

    logic                 l_neg, r_neg, d_neg;
    logic                 l_ne, r_ne, same_sign, l_ge_r;
    logic [PW-1:0]        sum_mag;
    logic                 sum_neg;

    logic                 red_start, red_done;
    logic [PW-1:0]        red_num, red_den;

    logic                 out_neg, ovf, reducing, res_ok, out_free;
    logic [FIELD_W-1:0]   mag_out, num_out;
    logic [STATUS_W-1:0]  status_out;

    assign in_an = mag_of(s_tdata[FIELD_W-1:0]);
    assign in_ad = mag_of(s_tdata[2*FIELD_W-1:FIELD_W]);
    assign in_bn = mag_of(s_tdata[3*FIELD_W-1:2*FIELD_W]);
    assign in_bd = mag_of(s_tdata[4*FIELD_W-1:3*FIELD_W]);
    assign uses_b = (s_tuser == KIND_ADD) || (s_tuser == KIND_MUL) ||
                    (s_tuser == KIND_DIV) || (s_tuser == KIND_EQUAL);

    // Cross products go through the one multiplier in S_MUL0, S_MUL1 and S_MUL2:
    // the numerator term, the second add term, then the denominator.
    always_comb begin
        mul_x = an_reg;
        mul_y = ONE_W;
        unique case (state_reg)
            S_MUL0: begin
                mul_x = (kind_reg == KIND_RECIP) ? ad_reg : an_reg;
                if (kind_reg == KIND_MUL) begin
                    mul_y = bn_reg;
                end else if (kind_reg == KIND_MAKE || kind_reg == KIND_RECIP) begin
                    mul_y = ONE_W;
                end else begin
                    mul_y = bd_reg;
                end
            end
            S_MUL1: begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            S_MUL2: begin
                mul_x = (kind_reg == KIND_RECIP) ? an_reg : ad_reg;
                if (kind_reg == KIND_ADD || kind_reg == KIND_MUL) begin
                    mul_y = bd_reg;
                end else if (kind_reg == KIND_DIV) begin
                    mul_y = bn_reg;
                end else begin
                    mul_y = ONE_W;
                end
            end
            default: begin
                mul_x = an_reg;
                mul_y = ONE_W;
            end
        endcase
    end

    rau_mul #(
        .WIDTH (W)
    ) u_mul (
        .aclk (aclk),
        .x    (mul_x),
        .y    (mul_y),
        .p    (prod)
    );

    // Signs of the three products follow the same operand choice.
    always_comb begin
        unique case (kind_reg)
            KIND_MAKE: begin
                l_neg = an_neg_reg;
                d_neg = ad_neg_reg;
            end
            KIND_MUL: begin
                l_neg = an_neg_reg ^ bn_neg_reg;
                d_neg = ad_neg_reg ^ bd_neg_reg;
            end
            KIND_DIV: begin
                l_neg = an_neg_reg ^ bd_neg_reg;
                d_neg = ad_neg_reg ^ bn_neg_reg;
            end
            KIND_RECIP: begin
                l_neg = ad_neg_reg;
                d_neg = an_neg_reg;
            end
            default: begin
                l_neg = an_neg_reg ^ bd_neg_reg;
                d_neg = ad_neg_reg ^ bd_neg_reg;
            end
        endcase
    end

    assign r_neg     = bn_neg_reg ^ ad_neg_reg;
    assign l_ne      = l_neg && (l_reg != '0);
    assign r_ne      = r_neg && (r_reg != '0);
    assign same_sign = (l_ne == r_ne);
    assign l_ge_r    = l_reg >= r_reg;

    // Signed-magnitude sum of the add terms; other kinds pass the first term on.
    always_comb begin
        if (kind_reg != KIND_ADD) begin
            sum_mag = l_reg;
            sum_neg = l_neg;
        end else if (same_sign) begin
            sum_mag = l_reg + r_reg;
            sum_neg = l_ne;
        end else if (l_ge_r) begin
            sum_mag = l_reg - r_reg;
            sum_neg = l_ne;
        end else begin
            sum_mag = r_reg - l_reg;
            sum_neg = r_ne;
        end
    end

    assign red_start = (state_reg == S_GO);

    rau_red #(
        .VAL_W (PW)
    ) u_red (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .n_in    (n_reg),
        .d_in    (d_reg),
        .done    (red_done),
        .q_num   (red_num),
        .q_den   (red_den)
    );

    // Final range check and formatting of the reduced fraction.
    assign out_neg  = sign_reg && (red_num != '0);
    assign ovf      = (red_den >= HALF) || (out_neg ? (red_num > HALF) : (red_num >= HALF));
    assign reducing = (st_reg == ST_OK) && (kind_reg <= KIND_RECIP);
    assign res_ok   = reducing && !ovf;
    assign mag_out  = FIELD_W'(red_num);
    assign num_out  = out_neg ? (~mag_out + FIELD_W'(1)) : mag_out;
    assign status_out = (st_reg != ST_OK) ? st_reg :
                        ((reducing && ovf) ? ST_OVERFLOW : ST_OK);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        an_next       = an_reg;
        ad_next       = ad_reg;
        bn_next       = bn_reg;
        bd_next       = bd_reg;
        an_neg_next   = an_neg_reg;
        ad_neg_next   = ad_neg_reg;
        bn_neg_next   = bn_neg_reg;
        bd_neg_next   = bd_neg_reg;
        st_next       = st_reg;
        eq_next       = eq_reg;
        sign_next     = sign_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    an_next     = in_an;
                    ad_next     = in_ad;
                    bn_next     = in_bn;
                    bd_next     = in_bd;
                    an_neg_next = s_tdata[W-1];
                    ad_neg_next = s_tdata[FIELD_W+W-1];
                    bn_neg_next = s_tdata[2*FIELD_W+W-1];
                    bd_neg_next = s_tdata[3*FIELD_W+W-1];
                    eq_next     = 1'b0;
                    st_next     = ST_OK;
                    if (s_tuser > KIND_EQUAL) begin
                        state_next = S_FIN;
                    end else if (in_ad == '0 || (uses_b && in_bd == '0)) begin
                        st_next    = ST_ZERO_DEN;
                        state_next = S_FIN;
                    end else if ((s_tuser == KIND_DIV && in_bn == '0) ||
                                 (s_tuser == KIND_RECIP && in_an == '0)) begin
                        st_next    = ST_DIV_ZERO;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                state_next = S_MUL1;
            end
            S_MUL1: begin
                l_next     = prod;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                r_next     = prod;
                state_next = S_SUM;
            end
            S_SUM: begin
                d_next    = prod;
                n_next    = sum_mag;
                sign_next = sum_neg ^ d_neg;
                eq_next   = (kind_reg == KIND_EQUAL) && same_sign && (l_reg == r_reg);
                state_next = (kind_reg == KIND_EQUAL) ? S_FIN : S_GO;
            end
            S_GO: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (red_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(st_reg == ST_OK) && eq_reg,
                                     res_ok ? RES_DEN_W'(red_den) : {RES_DEN_W{1'b0}},
                                     res_ok ? num_out : {FIELD_W{1'b0}}};
                    m_tuser_next  = status_out;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        an_neg_reg  <= an_neg_next;
        ad_neg_reg  <= ad_neg_next;
        bn_neg_reg  <= bn_neg_next;
        bd_neg_reg  <= bd_neg_next;
        st_reg      <= st_next;
        eq_reg      <= eq_next;
        sign_reg    <= sign_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "word accepted while another is in progress")
    `ASSERT_IMPLIES(a_error_fields_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "flagged result carries nonzero fields")
    `ASSERT_IMPLIES(a_equal_alone, aclk, aresetn, m_tvalid && m_tdata[OUT_DATA_W-1], (m_tdata[OUT_DATA_W-2:0] == '0) && (m_tuser == ST_OK), "equal flag set beside a fraction or a status")
    `ASSERT_IMPLIES(a_done_when_waiting, aclk, aresetn, red_done, state_reg == S_WAIT, "reduction finished outside its wait state")

endmodule

`default_nettype wire

FILE: sim/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the rational arithmetic unit: queued stimulus, prediction, checks.
module tb_rational_arithmetic_unit
    import rau_pkg::*;
();

    localparam int WB            = WORD_BITS_DEF;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_WORDS  = 700;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int HOLD_AT_WORD  = 60;
    localparam int HOLD_CYCLES   = 2500;

    // Kinds that the block treats as unused.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Handshake pacing phases, stepped every hundred accepted words.
    localparam int PH_NONE     = 0;
    localparam int PH_SENDER   = 1;
    localparam int PH_RECEIVER = 2;
    localparam int PH_BOTH     = 3;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [IN_DATA_W-1:0] data;
    } op_word_t;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [IN_DATA_W-1:0] data;
        logic [31:0]          res_num;
        logic [30:0]          res_den;
        logic                 equal;
        logic [STATUS_W-1:0]  status;
    } fraction_result_t;

    typedef struct {
        bit        neg;
        bit [63:0] mag;
    } sign_mag_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    op_word_t         pending_words[$];
    fraction_result_t expected_results[$];

    int words_sent    = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int hold_count    = 0;
    bit hold_started  = 1'b0;

    rational_arithmetic_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------------------------------------------------------- prediction

    function automatic sign_mag_t to_sign_mag(input logic [31:0] raw);
        bit [63:0] span;
        bit [63:0] v;
        sign_mag_t r;
        span = 64'd1 << WB;
        v = {32'd0, raw} & (span - 64'd1);
        r.neg = (v & (span >> 1)) != 0;
        r.mag = r.neg ? span - v : v;
        return r;
    endfunction

    function automatic sign_mag_t sm_mul(input sign_mag_t x, input sign_mag_t y);
        sign_mag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic sign_mag_t sm_add(input sign_mag_t x, input sign_mag_t y);
        sign_mag_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic bit [63:0] gcd64(input bit [63:0] x, input bit [63:0] y);
        bit [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduces n/d by the GCD of the magnitudes; the sign ends up on the numerator.
    function automatic logic [STATUS_W-1:0] reduce_fraction(input sign_mag_t n, input sign_mag_t d,
                                                            output logic [31:0] num,
                                                            output logic [30:0] den);
        bit [63:0] half;
        bit [63:0] nm;
        bit [63:0] dm;
        bit [63:0] g;
        bit        neg;
        num  = '0;
        den  = '0;
        half = 64'd1 << (WB - 1);
        nm   = n.mag;
        dm   = d.mag;
        neg  = (nm != 0) && (n.neg != d.neg);
        if (nm == 0) begin
            dm = 64'd1;
        end else begin
            g  = gcd64(nm, dm);
            nm = nm / g;
            dm = dm / g;
        end
        if (dm > half - 64'd1 || nm > (neg ? half : half - 64'd1)) return ST_OVERFLOW;
        num = neg ? 32'(64'd0 - nm) : nm[31:0];
        den = dm[30:0];
        return ST_OK;
    endfunction

    function automatic fraction_result_t predict_fraction(input logic [KIND_W-1:0] kind,
                                                          input logic [IN_DATA_W-1:0] data);
        sign_mag_t an, ad, bn, bd, lhs, rhs;
        bit uses_b;
        logic [STATUS_W-1:0] st;
        fraction_result_t r;
        r.kind    = kind;
        r.data    = data;
        r.res_num = '0;
        r.res_den = '0;
        r.equal   = 1'b0;
        r.status  = ST_OK;
        st        = ST_OK;
        an = to_sign_mag(data[31:0]);
        ad = to_sign_mag(data[63:32]);
        bn = to_sign_mag(data[95:64]);
        bd = to_sign_mag(data[127:96]);
        uses_b = (kind == KIND_ADD) || (kind == KIND_MUL) || (kind == KIND_DIV) ||
                 (kind == KIND_EQUAL);
        if (kind > KIND_EQUAL) return r;
        // A zero denominator outranks every other fault.
        if (ad.mag == 0 || (uses_b && bd.mag == 0)) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        case (kind)
            KIND_MAKE: begin
                st = reduce_fraction(an, ad, r.res_num, r.res_den);
            end
            KIND_ADD: begin
                st = reduce_fraction(sm_add(sm_mul(an, bd), sm_mul(bn, ad)), sm_mul(ad, bd),
                                     r.res_num, r.res_den);
            end
            KIND_MUL: begin
                st = reduce_fraction(sm_mul(an, bn), sm_mul(ad, bd), r.res_num, r.res_den);
            end
            KIND_DIV: begin
                if (bn.mag == 0) st = ST_DIV_ZERO;
                else st = reduce_fraction(sm_mul(an, bd), sm_mul(ad, bn), r.res_num, r.res_den);
            end
            KIND_RECIP: begin
                if (an.mag == 0) st = ST_DIV_ZERO;
                else st = reduce_fraction(ad, an, r.res_num, r.res_den);
            end
            default: begin
                lhs = sm_mul(an, bd);
                rhs = sm_mul(bn, ad);
                r.equal = (lhs.neg == rhs.neg) && (lhs.mag == rhs.mag);
            end
        endcase
        if (st != ST_OK) begin
            r.res_num = '0;
            r.res_den = '0;
            r.equal   = 1'b0;
        end
        r.status = st;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [31:0] an,
                              input logic [31:0] ad, input logic [31:0] bn,
                              input logic [31:0] bd);
        op_word_t w;
        w.kind = kind;
        w.data = {bd, bn, ad, an};
        pending_words.push_back(w);
    endtask

    // Mostly small or moderately sized values with shared factors, so that results reduce
    // and stay in range; full-width values and the extremes make up the rest.
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: v = $urandom_range(0, 40) - 20;
            4: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'd1;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'd0;
                endcase
            end
            5, 6:    v = $urandom();
            7:       v = $urandom_range(0, 65535);
            default: v = $urandom_range(1, 12) * $urandom_range(1, 5000);
        endcase
        if (sel >= 7 && $urandom_range(0, 1) == 1) v = 32'd0 - v;
        return v;
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        if ($urandom_range(0, 99) < 3)
            return ($urandom_range(0, 1) == 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        return KIND_W'($urandom_range(0, 5));
    endfunction

    function automatic int pacing_phase(input int accepted);
        return (accepted / 100) % 4;
    endfunction

    function automatic bit sender_rests(input int phase);
        if (phase == PH_SENDER) return $urandom_range(0, 99) < 52;
        if (phase == PH_BOTH) return $urandom_range(0, 99) < 9;
        return 1'b0;
    endfunction

    function automatic bit receiver_rests(input int phase);
        if (phase == PH_RECEIVER) return $urandom_range(0, 99) < 52;
        if (phase == PH_BOTH) return $urandom_range(0, 99) < 9;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input fraction_result_t want,
                                   input logic [63:0] got, input logic [63:0] wanted);
        $display("MISMATCH %s: kind %0d operands %h got %h expected %h (result %0d)",
                 what, want.kind, want.data, got, wanted, results_seen);
        error_count++;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin : drive_words
        op_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_fraction(s_tuser, s_tdata));
                words_sent <= words_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && !sender_rests(pacing_phase(words_sent))) begin
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= w.data;
                    s_tuser  <= w.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // One long hold-off early in the run, while the sender keeps offering words.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_count <= 0;
        end else if (!hold_started && words_sent == HOLD_AT_WORD) begin
            hold_started <= 1'b1;
            hold_count   <= HOLD_CYCLES;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_count != 0) m_tready <= 1'b0;
        else m_tready <= !receiver_rests(pacing_phase(words_sent));
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin : check_results
        fraction_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                want = predict_fraction(KIND_MAKE, '0);
                report_mismatch("unexpected word", want, {62'd0, m_tuser}, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.res_num)
                    report_mismatch("res_num", want, m_tdata[31:0], want.res_num);
                if (m_tdata[62:32] !== want.res_den)
                    report_mismatch("res_den", want, m_tdata[62:32], want.res_den);
                if (m_tdata[63] !== want.equal)
                    report_mismatch("equal", want, m_tdata[63], want.equal);
                if (m_tuser !== want.status)
                    report_mismatch("status", want, m_tuser, want.status);
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding, %0d words unsent",
                     cycle_count, expected_results.size(), pending_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // Directed words: extremes, every kind and each fault.
        queue_word(KIND_MAKE,  32'd6, -32'sd4, 32'hDEAD_BEEF, 32'd0);   // b ignored
        queue_word(KIND_MAKE,  32'd0, -32'sd7, 32'd0, 32'd0);
        queue_word(KIND_MAKE,  32'h8000_0000, 32'd1, 32'd0, 32'd1);
        queue_word(KIND_MAKE,  32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1);
        queue_word(KIND_MAKE,  32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1);
        queue_word(KIND_MAKE,  32'd5, 32'd0, 32'd1, 32'd1);
        queue_word(KIND_ADD,   32'd1, 32'd2, 32'd1, 32'd3);
        queue_word(KIND_ADD,   32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        queue_word(KIND_ADD,   32'd1, 32'd2, -32'sd1, 32'd2);
        queue_word(KIND_ADD,   32'd1, 32'd2, 32'd1, 32'd0);
        queue_word(KIND_MUL,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_word(KIND_MUL,   32'd1, 32'd65536, 32'd1, 32'd65536);
        queue_word(KIND_MUL,   -32'sd3, 32'd4, 32'd4, -32'sd3);
        queue_word(KIND_DIV,   32'd1, 32'd2, 32'd0, 32'd5);
        queue_word(KIND_DIV,   32'd0, 32'd0, 32'd0, 32'd5);
        queue_word(KIND_DIV,   -32'sd7, 32'd3, 32'd14, 32'd9);
        queue_word(KIND_RECIP, 32'd0, 32'd5, 32'd0, 32'd0);
        queue_word(KIND_RECIP, -32'sd3, 32'd7, 32'd1, 32'd1);
        queue_word(KIND_RECIP, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
        queue_word(KIND_EQUAL, 32'd1, 32'd2, 32'd2, 32'd4);
        queue_word(KIND_EQUAL, 32'd1, 32'd2, -32'sd1, -32'sd2);
        queue_word(KIND_EQUAL, 32'h7FFF_FFFF, 32'd3, 32'h7FFF_FFFE, 32'd3);
        queue_word(KIND_EQUAL, 32'd1, 32'd0, 32'd1, 32'd1);
        queue_word(KIND_SPARE_LO, $urandom(), $urandom(), $urandom(), $urandom());
        queue_word(KIND_SPARE_HI, $urandom(), $urandom(), $urandom(), $urandom());

        repeat (RANDOM_WORDS)
            queue_word(random_kind(), random_operand(), random_operand(), random_operand(),
                       random_operand());

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid) @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Checked %0d results from %0d words: all six operations, unused kinds,",
                 results_seen, words_sent);
        $display("zero denominators, division by zero and overflow, under varied pacing.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
